[sv/tda_pkg.sv]
// ----------------------------------------------------------------------------
// tda_pkg
// Shared constants, codes and types of the typed device allocator.
// ----------------------------------------------------------------------------
package tda_pkg;

   localparam int NUM_SLOTS = 16;
   localparam int NUM_TYPES = 4;

   localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W  = SLOT_W + 1;
   localparam int RNG_W  = (CNT_W > 6) ? CNT_W : 6;

   localparam int JOB_W    = 24;
   localparam int LNUM_W   = 16;
   localparam int TYPE_W   = 2;
   localparam int BASE_W   = 4;
   localparam int COUNT_W  = 5;
   localparam int CODE_W   = 2;
   localparam int DSLOT_W  = 4;
   localparam int FREED_W  = 5;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 5;

   // register file: one base and one count per type
   localparam int CFG_TYPES     = 4;
   localparam int CSR_NUM_REGS  = 2 * CFG_TYPES;
   localparam logic CSR_SEL_BASE  = 1'b0;
   localparam logic CSR_SEL_COUNT = 1'b1;

   localparam logic [BASE_W-1:0]  BASE_RESET  [CFG_TYPES] = '{4'd0, 4'd2, 4'd5, 4'd9};
   localparam logic [COUNT_W-1:0] COUNT_RESET [CFG_TYPES] = '{5'd2, 5'd3, 5'd4, 5'd1};

   // transaction opcodes
   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RECLAIM = 1'b1;

   // result codes
   localparam logic [CODE_W-1:0] RC_OK       = 2'd0;
   localparam logic [CODE_W-1:0] RC_NO_FREE  = 2'd1;
   localparam logic [CODE_W-1:0] RC_NOT_HELD = 2'd2;

   typedef struct packed {
      logic             empty;
      logic [CNT_W-1:0] lo;
      logic [CNT_W-1:0] hi;
   } range_type;

   typedef struct packed {
      logic [JOB_W-1:0]  owner;
      logic [LNUM_W-1:0] logical;
   } slot_entry_type;

   typedef struct packed {
      logic                en;
      logic [SLOT_W-1:0]   addr;
      slot_entry_type      data;
   } mem_write_type;

   function automatic logic [DSLOT_W-1:0] slot_to_port(input logic [SLOT_W-1:0] s);
      logic [SLOT_W+DSLOT_W-1:0] wide;
      wide = {{DSLOT_W{1'b0}}, s};
      return wide[DSLOT_W-1:0];
   endfunction

   function automatic logic [FREED_W-1:0] count_to_port(input logic [CNT_W-1:0] c);
      logic [CNT_W+FREED_W-1:0] wide;
      wide = {{FREED_W{1'b0}}, c};
      return wide[FREED_W-1:0];
   endfunction

endpackage

[sv/tda_cfg.sv]
// ----------------------------------------------------------------------------
// tda_cfg
// Type base/count registers and clipped slot range lookup per type.
// ----------------------------------------------------------------------------
module tda_cfg (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tda_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tda_pkg::CSR_DATA_W-1:0]      csr_data,
   input  logic [tda_pkg::TYPE_W-1:0]          type_sel,
   output tda_pkg::range_type                  range_out
);

   logic [tda_pkg::BASE_W-1:0]  base_ff  [tda_pkg::CFG_TYPES];
   logic [tda_pkg::COUNT_W-1:0] count_ff [tda_pkg::CFG_TYPES];
   logic [tda_pkg::TYPE_W-1:0]  wr_type;
   logic                        wr_hit;
   logic [tda_pkg::RNG_W-1:0]   rng_lo;
   logic [tda_pkg::RNG_W-1:0]   rng_end;
   logic                        type_bad;

   assign csr_ready = 1'b1;
   assign wr_hit  = csr_valid && (csr_index < tda_pkg::CSR_IDX_W'(tda_pkg::CSR_NUM_REGS));
   assign wr_type = csr_index[tda_pkg::TYPE_W:1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < tda_pkg::CFG_TYPES; t++) begin
            base_ff[t]  <= tda_pkg::BASE_RESET[t];
            count_ff[t] <= tda_pkg::COUNT_RESET[t];
         end
      end else if (wr_hit) begin
         if (csr_index[0] == tda_pkg::CSR_SEL_BASE) begin
            base_ff[wr_type] <= csr_data[tda_pkg::BASE_W-1:0];
         end else begin
            count_ff[wr_type] <= csr_data[tda_pkg::COUNT_W-1:0];
         end
      end
   end

   always_comb begin
      type_bad = ({1'b0, type_sel} >= (tda_pkg::TYPE_W + 1)'(tda_pkg::NUM_TYPES));
      rng_lo   = tda_pkg::RNG_W'(base_ff[type_sel]);
      rng_end  = tda_pkg::RNG_W'(base_ff[type_sel]) + tda_pkg::RNG_W'(count_ff[type_sel]);
      if (rng_end > tda_pkg::RNG_W'(tda_pkg::NUM_SLOTS)) begin
         rng_end = tda_pkg::RNG_W'(tda_pkg::NUM_SLOTS);
      end
      range_out.empty = type_bad || (rng_lo >= rng_end);
      range_out.lo    = rng_lo[tda_pkg::CNT_W-1:0];
      range_out.hi    = rng_end[tda_pkg::CNT_W-1:0];
   end

endmodule

[sv/tda_slot_mem.sv]
// ----------------------------------------------------------------------------
// tda_slot_mem
// Owner and logical number storage, one write and one registered read port.
// ----------------------------------------------------------------------------
module tda_slot_mem (
   input  logic                          clock,
   input  tda_pkg::mem_write_type        wr,
   input  logic [tda_pkg::SLOT_W-1:0]    rd_addr,
   output tda_pkg::slot_entry_type       rd_data
);

   tda_pkg::slot_entry_type mem [tda_pkg::NUM_SLOTS];
   tda_pkg::slot_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/tda_engine.sv]
// ----------------------------------------------------------------------------
// tda_engine
// Request sequencer: slot scan, taken flags, memory update and result register.
// ----------------------------------------------------------------------------
module tda_engine (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_op,
   input  logic [tda_pkg::JOB_W-1:0]       req_job_id,
   input  logic [tda_pkg::LNUM_W-1:0]      req_logical_number,
   input  tda_pkg::range_type              range_in,
   output tda_pkg::mem_write_type          mem_wr,
   output logic [tda_pkg::SLOT_W-1:0]      mem_rd_addr,
   input  tda_pkg::slot_entry_type         mem_rd_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [tda_pkg::CODE_W-1:0]      rsp_result_code,
   output logic [tda_pkg::DSLOT_W-1:0]     rsp_device_slot,
   output logic [tda_pkg::FREED_W-1:0]     rsp_freed_count
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type                          state_ff, state_in;
   logic                               op_ff, op_in;
   logic [tda_pkg::JOB_W-1:0]          job_ff, job_in;
   logic [tda_pkg::LNUM_W-1:0]         lnum_ff, lnum_in;
   logic [tda_pkg::CNT_W-1:0]          scan_ff, scan_in;
   logic [tda_pkg::CNT_W-1:0]          hi_ff, hi_in;
   logic [tda_pkg::CNT_W-1:0]          freed_ff, freed_in;
   logic                               found_ff, found_in;
   logic [tda_pkg::SLOT_W-1:0]         slot_ff, slot_in;
   logic                               pend_ff, pend_in;
   logic [tda_pkg::SLOT_W-1:0]         cmp_slot_ff, cmp_slot_in;
   logic [tda_pkg::NUM_SLOTS-1:0]      taken_ff, taken_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [tda_pkg::CODE_W-1:0]         rsp_code_ff, rsp_code_in;
   logic [tda_pkg::DSLOT_W-1:0]        rsp_slot_ff, rsp_slot_in;
   logic [tda_pkg::FREED_W-1:0]        rsp_freed_ff, rsp_freed_in;
   logic [tda_pkg::CNT_W-1:0]          scan_inc;
   logic [tda_pkg::SLOT_W-1:0]         scan_idx;

   assign scan_inc    = scan_ff + tda_pkg::CNT_W'(1);
   assign scan_idx    = scan_ff[tda_pkg::SLOT_W-1:0];
   assign mem_rd_addr = scan_idx;
   assign req_stall   = (state_ff != ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      job_in       = job_ff;
      lnum_in      = lnum_ff;
      scan_in      = scan_ff;
      hi_in        = hi_ff;
      freed_in     = freed_ff;
      found_in     = found_ff;
      slot_in      = slot_ff;
      pend_in      = pend_ff;
      cmp_slot_in  = cmp_slot_ff;
      taken_in     = taken_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_code_in  = rsp_code_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_freed_in = rsp_freed_ff;
      mem_wr       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_op;
               job_in   = req_job_id;
               lnum_in  = req_logical_number;
               scan_in  = range_in.lo;
               hi_in    = range_in.hi;
               freed_in = '0;
               found_in = 1'b0;
               slot_in  = '0;
               pend_in  = 1'b0;
               state_in = range_in.empty ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (op_ff == tda_pkg::OP_ALLOC) begin
               if (!taken_ff[scan_idx]) begin
                  taken_in[scan_idx]   = 1'b1;
                  mem_wr.en            = 1'b1;
                  mem_wr.addr          = scan_idx;
                  mem_wr.data.owner    = job_ff;
                  mem_wr.data.logical  = lnum_ff;
                  found_in             = 1'b1;
                  slot_in              = scan_idx;
                  state_in             = ST_FINISH;
               end else begin
                  scan_in = scan_inc;
                  if (scan_inc == hi_ff) begin
                     state_in = ST_FINISH;
                  end
               end
            end else begin
               // compare the entry read last cycle while the next read goes out
               if (pend_ff && taken_ff[cmp_slot_ff] && (mem_rd_data.owner == job_ff)) begin
                  taken_in[cmp_slot_ff] = 1'b0;
                  mem_wr.en             = 1'b1;
                  mem_wr.addr           = cmp_slot_ff;
                  freed_in              = freed_ff + tda_pkg::CNT_W'(1);
               end
               if (scan_ff != hi_ff) begin
                  pend_in     = 1'b1;
                  cmp_slot_in = scan_idx;
                  scan_in     = scan_inc;
               end else begin
                  pend_in = 1'b0;
                  if (!pend_ff) begin
                     state_in = ST_FINISH;
                  end
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               if (op_ff == tda_pkg::OP_ALLOC) begin
                  rsp_code_in  = found_ff ? tda_pkg::RC_OK : tda_pkg::RC_NO_FREE;
                  rsp_slot_in  = found_ff ? tda_pkg::slot_to_port(slot_ff) : '0;
                  rsp_freed_in = '0;
               end else begin
                  rsp_code_in  = (freed_ff == '0) ? tda_pkg::RC_NOT_HELD : tda_pkg::RC_OK;
                  rsp_slot_in  = '0;
                  rsp_freed_in = tda_pkg::count_to_port(freed_ff);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         taken_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         taken_ff     <= taken_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      job_ff       <= job_in;
      lnum_ff      <= lnum_in;
      scan_ff      <= scan_in;
      hi_ff        <= hi_in;
      freed_ff     <= freed_in;
      found_ff     <= found_in;
      slot_ff      <= slot_in;
      cmp_slot_ff  <= cmp_slot_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_freed_ff <= rsp_freed_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_code = rsp_code_ff;
   assign rsp_device_slot = rsp_slot_ff;
   assign rsp_freed_count = rsp_freed_ff;

endmodule

[sv/typed_device_allocator.sv]
// ----------------------------------------------------------------------------
// typed_device_allocator
// Device allocation table with four typed slot ranges, first-fit allocate
// and per-job reclaim.
// Sequence: an empty range goes straight to the result; allocate scans the
// range first-fit and stops at the first free slot; reclaim reads every slot
// in the range and frees each one owned by the requesting job.
// Throughput: one request at a time, one slot scanned per cycle (reclaim via
// the owner memory read port); a waiting result does not block acceptance.
// Reset: clears control state and every taken flag at once, no sweep.
// ----------------------------------------------------------------------------
module typed_device_allocator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_op,
   input  logic [tda_pkg::JOB_W-1:0]           req_job_id,
   input  logic [tda_pkg::TYPE_W-1:0]          req_type_index,
   input  logic [tda_pkg::LNUM_W-1:0]          req_logical_number,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [tda_pkg::CODE_W-1:0]          rsp_result_code,
   output logic [tda_pkg::DSLOT_W-1:0]         rsp_device_slot,
   output logic [tda_pkg::FREED_W-1:0]         rsp_freed_count,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tda_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tda_pkg::CSR_DATA_W-1:0]      csr_data
);

   tda_pkg::range_type          type_range;
   tda_pkg::mem_write_type      mem_wr;
   logic [tda_pkg::SLOT_W-1:0]  mem_rd_addr;
   tda_pkg::slot_entry_type     mem_rd_data;

   tda_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .type_sel  (req_type_index),
      .range_out (type_range)
   );

   tda_slot_mem u_mem (
      .clock   (clock),
      .wr      (mem_wr),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   tda_engine u_engine (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_job_id         (req_job_id),
      .req_logical_number (req_logical_number),
      .range_in           (type_range),
      .mem_wr             (mem_wr),
      .mem_rd_addr        (mem_rd_addr),
      .mem_rd_data        (mem_rd_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_code    (rsp_result_code),
      .rsp_device_slot    (rsp_device_slot),
      .rsp_freed_count    (rsp_freed_count)
   );

endmodule
